// File: hdl/two_wire_sensor_measure_master_core_defines.svh
// assertion macros for the two-wire sensor master
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TWO_WIRE_SENSOR_MEASURE_MASTER_CORE_DEFINES_SVH
`define TWO_WIRE_SENSOR_MEASURE_MASTER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TWSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TWSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/twsm_pkg.sv
// shared types and constants for the two-wire sensor master
// no dependencies
package twsm_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_TEMP     = 2'd1;
  localparam logic [1:0] REQ_HUMID    = 2'd2;
  localparam logic [1:0] REQ_BUS_RST  = 2'd3;

  // sensor command bytes
  localparam logic [7:0] CMD_TEMP  = 8'h03;
  localparam logic [7:0] CMD_HUMID = 8'h05;

  // configuration register indexes
  localparam int unsigned  CFG_IDX_W           = 2;
  localparam int unsigned  CFG_DATA_W          = 16;
  localparam logic [1:0]   CFG_PHASE_TICKS     = 2'd0;
  localparam logic [1:0]   CFG_POLL_INTERVAL   = 2'd1;
  localparam logic [1:0]   CFG_POLL_LIMIT      = 2'd2;

  // configuration reset values
  localparam logic [7:0]  PHASE_TICKS_RST   = 8'd4;
  localparam logic [15:0] POLL_INTERVAL_RST = 16'd1000;
  localparam logic [15:0] POLL_LIMIT_RST    = 16'd2000;

  localparam int unsigned RESET_PULSES_DEF = 9;

  // start pattern, bit i is step i
  localparam logic [6:0] START_CLK  = 7'b0110110;
  localparam logic [6:0] START_PULL = 7'b0011100;

  typedef struct packed {
    logic [7:0]  phase_ticks;
    logic [15:0] poll_interval;
    logic [15:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    logic        clock_out;
    logic        data_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        failed;
    logic [15:0] reading;
    logic [7:0]  checksum_byte;
  } res_t;

endpackage

// File: hdl/twsm_req_if.sv
// request channel: one beat is one tick with request code and data pin sample
// no dependencies
interface twsm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       data_pin;

  modport source (output valid, output req_type, output data_pin, input ready);
  modport sink   (input valid, input req_type, input data_pin, output ready);
endinterface

// File: hdl/twsm_res_if.sv
// result channel: one beat per tick with pin levels and status
// no dependencies
interface twsm_res_if;
  logic        valid;
  logic        ready;
  logic        clock_out;
  logic        data_pull_low;
  logic        busy_res;
  logic        done_res;
  logic        failed;
  logic [15:0] reading;
  logic [7:0]  checksum_byte;

  modport source (output valid, output clock_out, output data_pull_low, output busy_res,
                  output done_res, output failed, output reading, output checksum_byte,
                  input ready);
  modport sink   (input valid, input clock_out, input data_pull_low, input busy_res,
                  input done_res, input failed, input reading, input checksum_byte,
                  output ready);
endinterface

// File: hdl/twsm_seq.sv
// tick sequencer: bus state, counters and next-result logic
// depends on twsm_pkg
module twsm_seq #(
  parameter int unsigned RESET_PULSES = twsm_pkg::RESET_PULSES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  twsm_pkg::cfg_t  cfg_i,
  input  logic [1:0]      req_type_i,
  input  logic            data_pin_i,
  output twsm_pkg::res_t  res_o
);
  import twsm_pkg::*;

  localparam logic [7:0] RstPulses = 8'(RESET_PULSES);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RST     = 3'd1;
  localparam logic [2:0] ST_START_M = 3'd2;
  localparam logic [2:0] ST_SEND    = 3'd3;
  localparam logic [2:0] ST_WAIT    = 3'd4;
  localparam logic [2:0] ST_RECV    = 3'd5;
  localparam logic [2:0] ST_END     = 3'd6;
  localparam logic [2:0] ST_START_R = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [7:0]  phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [1:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] reading_q, reading_d;
  logic [7:0]  csum_q, csum_d;
  logic [15:0] pticks_q, pticks_d;
  logic [15:0] pcount_q, pcount_d;
  logic        err_q, err_d;
  logic        half_q, half_d;

  logic        clk_lvl, pull_lvl, done, fail;
  logic [7:0]  phase_eff, phase_inc;
  logic        phase_end;
  logic [15:0] interval_eff;
  logic [2:0]  start_idx;

  assign phase_eff    = (cfg_i.phase_ticks == 8'd0) ? 8'd1 : cfg_i.phase_ticks;
  assign interval_eff = (cfg_i.poll_interval == 16'd0) ? 16'd1 : cfg_i.poll_interval;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    reading_d = reading_q;
    csum_d    = csum_q;
    pticks_d  = pticks_q;
    pcount_d  = pcount_q;
    err_d     = err_q;
    half_d    = half_q;
    clk_lvl   = 1'b0;
    pull_lvl  = 1'b0;
    done      = 1'b0;
    fail      = 1'b0;
    start_idx = 3'd0;

    // launch a new request from idle
    if (state_q == ST_IDLE && req_type_i != REQ_TICK) begin
      phase_d = '0;
      bit_d   = '0;
      byte_d  = '0;
      half_d  = 1'b0;
      err_d   = 1'b0;
      if (req_type_i == REQ_BUS_RST) begin
        shift_d = '0;
        state_d = ST_RST;
      end else begin
        shift_d   = (req_type_i == REQ_TEMP) ? CMD_TEMP : CMD_HUMID;
        reading_d = '0;
        csum_d    = '0;
        state_d   = ST_START_M;
      end
    end

    phase_end = ({1'b0, phase_d} + 9'd1) >= {1'b0, phase_eff};
    phase_inc = phase_end ? 8'd0 : phase_d + 8'd1;

    case (state_d)
      ST_RST: begin
        clk_lvl = ~half_d;
        phase_d = phase_inc;
        if (phase_end) begin
          if (half_d) begin
            half_d  = 1'b0;
            shift_d = shift_d + 8'd1;
            if (shift_d >= RstPulses) begin
              state_d = ST_START_R;
              bit_d   = '0;
            end
          end else begin
            half_d = 1'b1;
          end
        end
      end
      ST_START_M, ST_START_R: begin
        start_idx = (bit_d > 4'd6) ? 3'd6 : bit_d[2:0];
        clk_lvl   = START_CLK[start_idx];
        pull_lvl  = START_PULL[start_idx];
        phase_d   = phase_inc;
        if (phase_end) begin
          if (start_idx == 3'd6) begin
            bit_d  = '0;
            half_d = 1'b0;
            if (state_d == ST_START_M) begin
              state_d = ST_SEND;
            end else begin
              state_d = ST_IDLE;
              done    = 1'b1;
            end
          end else begin
            bit_d = {1'b0, start_idx + 3'd1};
          end
        end
      end
      ST_SEND: begin
        clk_lvl = half_d;
        if (!bit_d[3]) begin
          pull_lvl = ~shift_d[3'd7 - bit_d[2:0]];
        end
        phase_d = phase_inc;
        if (phase_end) begin
          if (!half_d) begin
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            if (bit_d[3]) begin
              // acknowledge clock: sample the acknowledge
              err_d    = data_pin_i;
              state_d  = ST_WAIT;
              pticks_d = '0;
              pcount_d = '0;
              bit_d    = '0;
            end else begin
              bit_d = bit_d + 4'd1;
            end
          end
        end
      end
      ST_WAIT: begin
        if (pticks_d == 16'd0) begin
          if (!data_pin_i) begin
            if (err_d) begin
              state_d = ST_IDLE;
              done    = 1'b1;
              fail    = 1'b1;
            end else begin
              state_d = ST_RECV;
              bit_d   = '0;
              byte_d  = '0;
              half_d  = 1'b0;
              phase_d = '0;
              shift_d = '0;
            end
          end else if (pcount_d >= cfg_i.poll_limit) begin
            err_d   = 1'b1;
            state_d = ST_IDLE;
            done    = 1'b1;
            fail    = 1'b1;
          end else begin
            pcount_d = pcount_d + 16'd1;
            pticks_d = interval_eff - 16'd1;
          end
        end else begin
          pticks_d = pticks_d - 16'd1;
        end
      end
      ST_RECV: begin
        clk_lvl  = half_d;
        pull_lvl = bit_d[3] && (byte_d < 2'd2);
        phase_d  = phase_inc;
        if (phase_end) begin
          if (!half_d) begin
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            if (!bit_d[3]) begin
              shift_d = {shift_d[6:0], data_pin_i};
              bit_d   = bit_d + 4'd1;
            end else begin
              if (byte_d == 2'd0) begin
                reading_d = {shift_d, 8'h00};
              end else if (byte_d == 2'd1) begin
                reading_d = {reading_d[15:8], shift_d};
              end else begin
                csum_d = shift_d;
              end
              shift_d = '0;
              bit_d   = '0;
              byte_d  = byte_d + 2'd1;
              if (byte_d == 2'd3) begin
                state_d = ST_END;
                byte_d  = '0;
              end
            end
          end
        end
      end
      ST_END: begin
        phase_d = phase_inc;
        if (phase_end) begin
          state_d = ST_IDLE;
          done    = 1'b1;
          fail    = err_d;
        end
      end
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o.clock_out     = clk_lvl;
    res_o.data_pull_low = pull_lvl;
    res_o.busy_res      = (state_d != ST_IDLE);
    res_o.done_res      = done;
    res_o.failed        = done & fail;
    res_o.reading       = reading_d;
    res_o.checksum_byte = csum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= '0;
      bit_q     <= '0;
      byte_q    <= '0;
      shift_q   <= '0;
      reading_q <= '0;
      csum_q    <= '0;
      pticks_q  <= '0;
      pcount_q  <= '0;
      err_q     <= 1'b0;
      half_q    <= 1'b0;
    end else if (step_i) begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      shift_q   <= shift_d;
      reading_q <= reading_d;
      csum_q    <= csum_d;
      pticks_q  <= pticks_d;
      pcount_q  <= pcount_d;
      err_q     <= err_d;
      half_q    <= half_d;
    end
  end

endmodule

// File: hdl/two_wire_sensor_measure_master_core.sv
// top level of the two-wire humidity and temperature sensor master
// depends on twsm_pkg, twsm_req_if, twsm_res_if, twsm_seq and the defines header
//
// Each request beat is one bus tick: it carries a request code (tick only,
// temperature, humidity, bus reset) and the sampled level of the data line,
// and yields exactly one result beat with the clock level, the data pull-low,
// busy, a one-beat done pulse with its fail flag, the last 16-bit reading and
// the last raw checksum byte. One beat is taken per clock cycle: the sequencer
// computes the whole tick combinationally between its state registers and the
// result register, so the request channel stays ready whenever the result
// register is empty or is being drained in the same cycle. Bus timing is
// counted in beats, not clock cycles, set by the phase_ticks, poll_interval and
// poll_limit registers: the user must write them only while idle; not enforced.
`include "two_wire_sensor_measure_master_core_defines.svh"

module two_wire_sensor_measure_master_core #(
  parameter int unsigned RESET_PULSES = twsm_pkg::RESET_PULSES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  twsm_req_if.sink                             req_i,
  twsm_res_if.source                           res_o,
  input  logic                                 cfg_we_i,
  input  logic [twsm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [twsm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import twsm_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks   <= PHASE_TICKS_RST;
      cfg_q.poll_interval <= POLL_INTERVAL_RST;
      cfg_q.poll_limit    <= POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_TICKS:   cfg_q.phase_ticks   <= cfg_wdata_i[7:0];
        CFG_POLL_INTERVAL: cfg_q.poll_interval <= cfg_wdata_i[15:0];
        CFG_POLL_LIMIT:    cfg_q.poll_limit    <= cfg_wdata_i[15:0];
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  // request beat accepted when the result slot is free or draining
  logic res_valid_q;
  logic req_accept;
  res_t res_d, res_q;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign req_accept  = req_i.valid && req_i.ready;

  // one-tick sequencer, state advances only on an accepted beat
  twsm_seq #(
    .RESET_PULSES (RESET_PULSES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (req_accept),
    .cfg_i      (cfg_q),
    .req_type_i (req_i.req_type),
    .data_pin_i (req_i.data_pin),
    .res_o      (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (req_accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.clock_out     = res_q.clock_out;
  assign res_o.data_pull_low = res_q.data_pull_low;
  assign res_o.busy_res      = res_q.busy_res;
  assign res_o.done_res      = res_q.done_res;
  assign res_o.failed        = res_q.failed;
  assign res_o.reading       = res_q.reading;
  assign res_o.checksum_byte = res_q.checksum_byte;

  // a finished request leaves the sequencer idle
  `TWSM_ASSERT_IMPL(a_done_not_busy, res_valid_q && res_q.done_res, !res_q.busy_res, "done while busy")
  // fail is only reported together with done
  `TWSM_ASSERT_IMPL(a_fail_with_done, res_valid_q && res_q.failed, res_q.done_res, "fail without done")
  // every accepted request beat fills the result register
  `TWSM_ASSERT_NEXT(a_accept_fills, req_accept, res_valid_q, "accepted beat lost")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for two_wire_sensor_measure_master_core, one bus tick per beat
// depends on twsm_pkg, twsm_req_if, twsm_res_if and the core; a tick-accurate sequencer
// model with a scripted sensor predicts every result beat

module tb_top;
  import twsm_pkg::*;

  // sequencer states of the local model
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_RST, SQ_START_M, SQ_SEND, SQ_WAIT, SQ_RECV, SQ_END, SQ_START_R
  } seq_e;

  // traffic shaping on both channels
  typedef enum logic [1:0] {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_e;

  // how the expected beat is formed: model only, fully typed, or typed done status
  typedef enum logic [1:0] {CHK_MODEL, CHK_WHOLE, CHK_DONE} chk_e;

  // register sets used by the directed rows
  typedef enum logic [1:0] {CFG_KEEP, CFG_FAST, CFG_SLOW_POLL} cfg_sel_e;

  localparam logic [15:0] NEVER_LOW = 16'hFFFF;
  localparam int          HOLD_CYCLES = 300;

  // one directed request with its sensor script and, where obvious, its outcome
  typedef struct packed {
    cfg_sel_e    cfg_sel;
    logic [1:0]  rq;
    logic        ack_hi;
    logic [15:0] polls_high;
    logic [23:0] rx;
    logic        typed;
    logic        t_fail;
    logic [15:0] t_reading;
    logic [7:0]  t_chk;
  } dir_row_t;

  localparam int N_DIR = 11;

  dir_row_t dir_rows [N_DIR] = '{
    // tick-only beats right after reset: everything low
    '{CFG_KEEP,      REQ_TICK,    1'b0, 16'd0,     24'h000000, 1'b1, 1'b0, 16'h0000, 8'h00},
    '{CFG_KEEP,      REQ_TICK,    1'b0, 16'd0,     24'h000001, 1'b1, 1'b0, 16'h0000, 8'h00},
    // default timing, all-ones frame
    '{CFG_KEEP,      REQ_TEMP,    1'b0, 16'd0,     24'hFFFFFF, 1'b1, 1'b0, 16'hFFFF, 8'hFF},
    // shortest timing, one busy poll then all-zeros frame
    '{CFG_FAST,      REQ_HUMID,   1'b0, 16'd1,     24'h000000, 1'b1, 1'b0, 16'h0000, 8'h00},
    // missing acknowledge
    '{CFG_KEEP,      REQ_HUMID,   1'b1, 16'd0,     24'h123456, 1'b1, 1'b1, 16'h0000, 8'h00},
    // bus reset leaves reading and checksum alone
    '{CFG_KEEP,      REQ_BUS_RST, 1'b0, 16'd0,     24'h000000, 1'b1, 1'b0, 16'h0000, 8'h00},
    // sensor never finishes: wait timeout
    '{CFG_KEEP,      REQ_TEMP,    1'b0, NEVER_LOW, 24'h000000, 1'b1, 1'b1, 16'h0000, 8'h00},
    '{CFG_SLOW_POLL, REQ_TEMP,    1'b0, 16'd2,     24'hA53C96, 1'b1, 1'b0, 16'hA53C, 8'h96},
    '{CFG_KEEP,      REQ_BUS_RST, 1'b0, 16'd0,     24'h000000, 1'b1, 1'b0, 16'hA53C, 8'h96},
    // missing acknowledge and timeout together
    '{CFG_KEEP,      REQ_HUMID,   1'b1, NEVER_LOW, 24'h000000, 1'b1, 1'b1, 16'h0000, 8'h00},
    '{CFG_KEEP,      REQ_TEMP,    1'b0, 16'd1,     24'h5AC369, 1'b0, 1'b0, 16'h0000, 8'h00}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  twsm_req_if req_ch ();
  twsm_res_if res_ch ();

  two_wire_sensor_measure_master_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // sequencer model state
  seq_e        sq;
  logic [7:0]  ph_cnt;
  logic [3:0]  bit_cnt;
  logic [1:0]  byte_cnt;
  logic [7:0]  shreg;
  logic [15:0] rd_reg;
  logic [7:0]  ck_reg;
  logic [15:0] poll_left;
  logic [15:0] poll_num;
  logic        err;
  logic        half;

  // model copy of the registers
  logic [7:0]  cfg_phase;
  logic [15:0] cfg_interval;
  logic [15:0] cfg_limit;

  // script of the emulated sensor for the request in flight
  bit          scn_noise;
  bit          scn_ack_hi;
  int unsigned scn_polls_high;
  logic [23:0] scn_rx;

  // pin frames still owed by the core, oldest first
  res_t        frames_q [$];

  int          ticks_sent;
  int          requests_done;
  int          bad_beats;

  pace_e       pace;
  int          hold_seq;
  int          hold_seen = 0;
  int          hold_left = 0;

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop in case the core hangs
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // counts one tick of the current bus phase, true on its last tick
  function automatic bit phase_end();
    int unsigned pt;
    pt = (cfg_phase == 8'd0) ? 1 : cfg_phase;
    if (ph_cnt + 1 >= pt) begin
      ph_cnt = 8'd0;
      return 1'b1;
    end
    ph_cnt = ph_cnt + 8'd1;
    return 1'b0;
  endfunction

  // advances the sequencer model by one tick and returns the pin frame it drives
  function automatic res_t tick_sequencer(input logic [1:0] rq, input logic pin);
    res_t        r;
    logic        sclk;
    logic        pull;
    logic        done;
    logic        fail;
    logic [3:0]  idx;
    sclk = 1'b0;
    pull = 1'b0;
    done = 1'b0;
    fail = 1'b0;

    // a new request is taken only while idle
    if (sq == SQ_IDLE && rq != REQ_TICK) begin
      ph_cnt   = '0;
      bit_cnt  = '0;
      byte_cnt = '0;
      half     = 1'b0;
      err      = 1'b0;
      if (rq == REQ_BUS_RST) begin
        shreg = '0;
        sq    = SQ_RST;
      end else begin
        shreg  = (rq == REQ_TEMP) ? CMD_TEMP : CMD_HUMID;
        rd_reg = '0;
        ck_reg = '0;
        sq     = SQ_START_M;
      end
    end

    case (sq)
      SQ_RST: begin
        // clock pulses with data released, pulse count kept in the shifter
        sclk = ~half;
        if (phase_end()) begin
          if (half) begin
            half  = 1'b0;
            shreg = shreg + 8'd1;
            if (shreg >= RESET_PULSES_DEF) begin
              sq      = SQ_START_R;
              bit_cnt = '0;
            end
          end else begin
            half = 1'b1;
          end
        end
      end
      SQ_START_M, SQ_START_R: begin
        // transmission-start pattern, one step per phase
        idx  = (bit_cnt > 4'd6) ? 4'd6 : bit_cnt;
        sclk = START_CLK[idx];
        pull = START_PULL[idx];
        if (phase_end()) begin
          if (idx >= 4'd6) begin
            bit_cnt = '0;
            half    = 1'b0;
            if (sq == SQ_START_M) begin
              sq = SQ_SEND;
            end else begin
              sq   = SQ_IDLE;
              done = 1'b1;
            end
          end else begin
            bit_cnt = idx + 4'd1;
          end
        end
      end
      SQ_SEND: begin
        // command msb first, then an acknowledge clock samples the acknowledge
        sclk = half;
        if (bit_cnt < 4'd8) pull = ~shreg[7 - bit_cnt];
        if (phase_end()) begin
          if (!half) begin
            half = 1'b1;
          end else begin
            half = 1'b0;
            if (bit_cnt >= 4'd8) begin
              err       = pin;
              sq        = SQ_WAIT;
              poll_left = '0;
              poll_num  = '0;
              bit_cnt   = '0;
            end else begin
              bit_cnt = bit_cnt + 4'd1;
            end
          end
        end
      end
      SQ_WAIT: begin
        // polls the data line every interval until low or out of polls
        if (poll_left == 16'd0) begin
          if (!pin) begin
            if (err) begin
              sq   = SQ_IDLE;
              done = 1'b1;
              fail = 1'b1;
            end else begin
              sq       = SQ_RECV;
              bit_cnt  = '0;
              byte_cnt = '0;
              half     = 1'b0;
              ph_cnt   = '0;
              shreg    = '0;
            end
          end else if (poll_num >= cfg_limit) begin
            err  = 1'b1;
            sq   = SQ_IDLE;
            done = 1'b1;
            fail = 1'b1;
          end else begin
            poll_num  = poll_num + 16'd1;
            poll_left = ((cfg_interval == 16'd0) ? 16'd1 : cfg_interval) - 16'd1;
          end
        end else begin
          poll_left = poll_left - 16'd1;
        end
      end
      SQ_RECV: begin
        // two acknowledged bytes, checksum left unacknowledged
        sclk = half;
        pull = (bit_cnt >= 4'd8 && byte_cnt < 2'd2);
        if (phase_end()) begin
          if (!half) begin
            half = 1'b1;
          end else begin
            half = 1'b0;
            if (bit_cnt < 4'd8) begin
              shreg   = {shreg[6:0], pin};
              bit_cnt = bit_cnt + 4'd1;
            end else begin
              if (byte_cnt == 2'd0) rd_reg = {shreg, 8'h00};
              else if (byte_cnt == 2'd1) rd_reg[7:0] = shreg;
              else ck_reg = shreg;
              shreg    = '0;
              bit_cnt  = '0;
              byte_cnt = byte_cnt + 2'd1;
              if (byte_cnt >= 2'd3) begin
                sq       = SQ_END;
                byte_cnt = '0;
              end
            end
          end
        end
      end
      SQ_END: begin
        if (phase_end()) begin
          sq   = SQ_IDLE;
          done = 1'b1;
          fail = err;
        end
      end
      default: sq = SQ_IDLE;
    endcase

    r.clock_out     = sclk;
    r.data_pull_low = pull;
    r.busy_res      = (sq != SQ_IDLE);
    r.done_res      = done;
    r.failed        = done & fail;
    r.reading       = rd_reg;
    r.checksum_byte = ck_reg;
    return r;
  endfunction

  // level the emulated sensor puts on the data line for the next tick
  function automatic logic sensor_level();
    if (scn_noise) return ($urandom_range(1) == 1);
    case (sq)
      SQ_SEND: if (bit_cnt == 4'd8) return scn_ack_hi;
      SQ_WAIT: if (poll_left == 16'd0) return (poll_num < scn_polls_high);
      SQ_RECV: if (bit_cnt < 4'd8) return scn_rx[23 - 8 * byte_cnt - bit_cnt];
      default: ;
    endcase
    // the core ignores the line here
    return ($urandom_range(1) == 1);
  endfunction

  // random sensor behavior for a new request
  function automatic void pick_scenario();
    int unsigned iv;
    int unsigned km;
    iv = (cfg_interval == 16'd0) ? 1 : cfg_interval;
    // keep busy polls short in ticks
    km = 2000 / iv;
    if (km > cfg_limit) km = cfg_limit;
    if (km > 6) km = 6;
    // line noise only where a busy poll stays short
    scn_noise  = (km != 0) && ($urandom_range(99) < 12);
    scn_ack_hi = ($urandom_range(99) < 10);
    case ($urandom_range(3))
      0:       scn_rx = '0;
      1:       scn_rx = '1;
      default: scn_rx = 24'($urandom);
    endcase
    scn_polls_high = $urandom_range(km);
    // timeouts only where the full poll window stays short
    if ((cfg_limit + 1) * iv <= 4000 && $urandom_range(99) < 12) scn_polls_high = '1;
  endfunction

  function automatic bit sender_waits();
    case (pace)
      PACE_SEND: return ($urandom_range(99) < 74);
      PACE_BOTH: return ($urandom_range(99) < 16);
      default:   return 1'b0;
    endcase
  endfunction

  // one tick beat: offer at the falling edge, predict once taken
  task automatic drive_tick(input logic [1:0] rq, input logic pin, input chk_e mode,
                            input res_t want);
    res_t r;
    while (sender_waits()) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid    = 1'b1;
    req_ch.req_type = rq;
    req_ch.data_pin = pin;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    r = tick_sequencer(rq, pin);
    ticks_sent++;
    if (r.done_res) requests_done++;
    if (mode == CHK_WHOLE) begin
      r = want;
    end else if (mode == CHK_DONE && r.done_res) begin
      r.failed        = want.failed;
      r.reading       = want.reading;
      r.checksum_byte = want.checksum_byte;
    end
    frames_q.push_back(r);
    @(negedge clk_i);
  endtask

  // issues a request and ticks until the sequencer is idle again
  task automatic run_request(input logic [1:0] rq, input chk_e mode, input res_t want);
    drive_tick(rq, sensor_level(), CHK_MODEL, want);
    // request codes while busy must be ignored
    while (sq != SQ_IDLE) drive_tick(2'($urandom_range(3)), sensor_level(), mode, want);
  endtask

  // register writes once the result channel has drained, called at a falling edge
  task automatic write_regs(input logic [7:0] ph, input logic [15:0] iv,
                            input logic [15:0] lim);
    req_ch.valid = 1'b0;
    while (frames_q.size() != 0) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_PHASE_TICKS;
    cfg_wdata_i = {8'h00, ph};
    cfg_phase   = ph;
    @(negedge clk_i);
    cfg_idx_i    = CFG_POLL_INTERVAL;
    cfg_wdata_i  = iv;
    cfg_interval = iv;
    @(negedge clk_i);
    cfg_idx_i   = CFG_POLL_LIMIT;
    cfg_wdata_i = lim;
    cfg_limit   = lim;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // random traffic under one register set, ends with the sequencer idle
  task automatic run_phase(input logic [7:0] ph, input logic [15:0] iv, input logic [15:0] lim,
                           input pace_e pc, input int n_ticks, input int n_done,
                           input bit rst_only, input bit hold);
    int         t0;
    int         d0;
    logic [1:0] rq;
    write_regs(ph, iv, lim);
    pace = pc;
    if (hold) hold_seq++;
    t0 = ticks_sent;
    d0 = requests_done;
    while (ticks_sent - t0 < n_ticks || requests_done - d0 < n_done || sq != SQ_IDLE) begin
      if (sq == SQ_IDLE && $urandom_range(99) < 35) begin
        rq = rst_only ? REQ_BUS_RST : 2'($urandom_range(3, 1));
        pick_scenario();
      end else begin
        rq = (sq == SQ_IDLE) ? REQ_TICK : 2'($urandom_range(3));
      end
      drive_tick(rq, sensor_level(), CHK_MODEL, '0);
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      res_ch.ready = 1'b0;
      hold_left--;
    end else begin
      case (pace)
        PACE_RECV: res_ch.ready = ($urandom_range(99) >= 74);
        PACE_BOTH: res_ch.ready = ($urandom_range(99) >= 16);
        default:   res_ch.ready = 1'b1;
      endcase
    end
  end

  // compare each result beat with the oldest owed frame
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.clock_out     = res_ch.clock_out;
      got.data_pull_low = res_ch.data_pull_low;
      got.busy_res      = res_ch.busy_res;
      got.done_res      = res_ch.done_res;
      got.failed        = res_ch.failed;
      got.reading       = res_ch.reading;
      got.checksum_byte = res_ch.checksum_byte;
      if (frames_q.size() == 0) begin
        if (bad_beats < 10) $display("%0t result beat with nothing expected", $time);
        bad_beats++;
      end else begin
        want = frames_q.pop_front();
        if (got.clock_out !== want.clock_out || got.data_pull_low !== want.data_pull_low ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
            got.failed !== want.failed || got.reading !== want.reading ||
            got.checksum_byte !== want.checksum_byte) begin
          if (bad_beats < 10) begin
            $display("%0t mismatch exp/got: clk %b/%b pull %b/%b busy %b/%b done %b/%b fail %b/%b",
                     $time, want.clock_out, got.clock_out, want.data_pull_low,
                     got.data_pull_low, want.busy_res, got.busy_res, want.done_res,
                     got.done_res, want.failed, got.failed);
            $display("  reading %h/%h checksum %h/%h", want.reading, got.reading,
                     want.checksum_byte, got.checksum_byte);
          end
          bad_beats++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    res_t     want;
    // all inputs known from time zero
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.data_pin = 1'b0;
    pace            = PACE_NONE;
    hold_seq        = 0;
    ticks_sent      = 0;
    requests_done   = 0;
    bad_beats       = 0;

    // model state after reset
    sq           = SQ_IDLE;
    ph_cnt       = '0;
    bit_cnt      = '0;
    byte_cnt     = '0;
    shreg        = '0;
    rd_reg       = '0;
    ck_reg       = '0;
    poll_left    = '0;
    poll_num     = '0;
    err          = 1'b0;
    half         = 1'b0;
    cfg_phase    = PHASE_TICKS_RST;
    cfg_interval = POLL_INTERVAL_RST;
    cfg_limit    = POLL_LIMIT_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed requests, register defaults first
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.cfg_sel)
        CFG_FAST:      write_regs(8'd1, 16'd1, 16'd1);
        CFG_SLOW_POLL: write_regs(8'd1, 16'd3, 16'd2);
        default: ;
      endcase
      want               = '0;
      want.failed        = row.t_fail;
      want.reading       = row.t_reading;
      want.checksum_byte = row.t_chk;
      if (row.rq == REQ_TICK) begin
        drive_tick(REQ_TICK, row.rx[0], row.typed ? CHK_WHOLE : CHK_MODEL, '0);
      end else begin
        scn_noise      = 1'b0;
        scn_ack_hi     = row.ack_hi;
        scn_polls_high = (row.polls_high == NEVER_LOW) ? '1 : row.polls_high;
        scn_rx         = row.rx;
        run_request(row.rq, row.typed ? CHK_DONE : CHK_MODEL, want);
      end
    end

    // random traffic across register sets and pacing
    run_phase(8'd1,   16'd1,     16'd1,     PACE_NONE, 50, 1, 1'b0, 1'b0);
    run_phase(8'd1,   16'd2,     16'd3,     PACE_SEND, 50, 1, 1'b0, 1'b0);
    run_phase(8'd2,   16'd4,     16'd5,     PACE_RECV, 50, 1, 1'b0, 1'b0);
    run_phase(8'd1,   16'd1,     16'd65535, PACE_BOTH, 50, 1, 1'b0, 1'b0);
    // widest poll registers, sensor answers on the first poll
    run_phase(8'd3,   16'd65535, 16'd65535, PACE_NONE, 30, 1, 1'b0, 1'b0);
    // zero phase and interval registers act as one
    run_phase(8'd0,   16'd0,     16'd1,     PACE_NONE, 20, 1, 1'b0, 1'b0);
    // result side holds off while ticks keep coming, input must back up
    run_phase(8'd1,   16'd3,     16'd4,     PACE_NONE, 60, 1, 1'b0, 1'b1);

    // drain, then wait for any stray beats
    req_ch.valid = 1'b0;
    while (frames_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (bad_beats == 0 && frames_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
